### rtl/tbs_pkg.sv
// Shared types and constants for the TFTP block sender.
// Used by every module of the block and by its port checker.
package tbs_pkg;

   localparam int OP_W    = 3;
   localparam int BLOCK_W = 16;
   localparam int CODE_W  = 16;
   localparam int LEN_W   = 10;
   localparam int LIMIT_W = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [LEN_W-1:0] BLOCK_BYTES = LEN_W'(512);

   localparam logic [OP_W-1:0] OP_START   = 3'd0;
   localparam logic [OP_W-1:0] OP_ACK     = 3'd1;
   localparam logic [OP_W-1:0] OP_ERROR   = 3'd2;
   localparam logic [OP_W-1:0] OP_OTHER   = 3'd3;
   localparam logic [OP_W-1:0] OP_TIMEOUT = 3'd4;

   localparam logic [OP_W-1:0] ACT_SEND          = 3'd0;
   localparam logic [OP_W-1:0] ACT_RESEND        = 3'd1;
   localparam logic [OP_W-1:0] ACT_FINISH        = 3'd2;
   localparam logic [OP_W-1:0] ACT_PEER_ERR      = 3'd3;
   localparam logic [OP_W-1:0] ACT_PROTO_ERR     = 3'd4;
   localparam logic [OP_W-1:0] ACT_TIMEOUT_ABORT = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] REG_RETRY_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SERVER_MODE = 1'd1;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [BLOCK_W-1:0] rx_block;
      logic [CODE_W-1:0]  rx_error_code;
      logic [LEN_W-1:0]   chunk_length;
   } item_type;

   typedef struct packed {
      logic [OP_W-1:0]    action;
      logic [BLOCK_W-1:0] tx_block;
      logic [LEN_W-1:0]   tx_length;
      logic [CODE_W-1:0]  peer_error_code;
   } result_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] retry_limit;
      logic               server_mode;
   } cfg_type;

endpackage

### rtl/tbs_core.sv
// Transfer state and per-event decision logic of the TFTP block sender.
// Depends on tbs_pkg; state advances only when the caller asserts advance.
module tbs_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  tbs_pkg::item_type   item,
   input  tbs_pkg::cfg_type    cfg,
   output logic                res_valid,
   output tbs_pkg::result_type res
);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   phase_type                          phase_ff, phase_in;
   logic [tbs_pkg::BLOCK_W-1:0]        expected_block_ff, expected_block_in;
   logic                               final_sent_ff, final_sent_in;
   logic                               data_sent_once_ff, data_sent_once_in;
   logic [tbs_pkg::LIMIT_W-1:0]        timeout_count_ff, timeout_count_in;
   logic [tbs_pkg::LEN_W-1:0]          sent_length_ff, sent_length_in;

   logic [tbs_pkg::LEN_W-1:0]          sat_len;
   logic [tbs_pkg::LIMIT_W-1:0]        limit;
   logic [tbs_pkg::LIMIT_W-1:0]        timeout_inc;
   logic [tbs_pkg::BLOCK_W-1:0]        block_inc;

   assign sat_len = (item.chunk_length > tbs_pkg::BLOCK_BYTES) ?
                    tbs_pkg::BLOCK_BYTES : item.chunk_length;
   assign limit = (cfg.retry_limit == '0) ? tbs_pkg::LIMIT_W'(1) : cfg.retry_limit;
   assign timeout_inc = timeout_count_ff + tbs_pkg::LIMIT_W'(1);
   assign block_inc = expected_block_ff + tbs_pkg::BLOCK_W'(1);

   always_comb begin
      phase_in          = phase_ff;
      expected_block_in = expected_block_ff;
      final_sent_in     = final_sent_ff;
      data_sent_once_in = data_sent_once_ff;
      timeout_count_in  = timeout_count_ff;
      sent_length_in    = sent_length_ff;
      res_valid         = 1'b0;
      res               = '0;
      case (item.operation)
         tbs_pkg::OP_START: begin
            if (phase_ff != PH_WAIT) begin
               phase_in          = PH_WAIT;
               expected_block_in = '0;
               final_sent_in     = 1'b0;
               data_sent_once_in = 1'b0;
               timeout_count_in  = '0;
               sent_length_in    = '0;
               if (cfg.server_mode) begin
                  expected_block_in = tbs_pkg::BLOCK_W'(1);
                  sent_length_in    = sat_len;
                  final_sent_in     = (sat_len < tbs_pkg::BLOCK_BYTES);
                  data_sent_once_in = 1'b1;
                  res_valid         = 1'b1;
                  res.action        = tbs_pkg::ACT_SEND;
                  res.tx_block      = tbs_pkg::BLOCK_W'(1);
                  res.tx_length     = sat_len;
               end
            end
         end
         tbs_pkg::OP_ACK: begin
            if (phase_ff == PH_WAIT) begin
               timeout_count_in = '0;
               if (item.rx_block == expected_block_ff) begin
                  res_valid = 1'b1;
                  if (final_sent_ff) begin
                     phase_in   = PH_DONE;
                     res.action = tbs_pkg::ACT_FINISH;
                  end else begin
                     expected_block_in = block_inc;
                     sent_length_in    = sat_len;
                     final_sent_in     = (sat_len < tbs_pkg::BLOCK_BYTES);
                     data_sent_once_in = 1'b1;
                     res.action        = tbs_pkg::ACT_SEND;
                     res.tx_block      = block_inc;
                     res.tx_length     = sat_len;
                  end
               end
            end
         end
         tbs_pkg::OP_ERROR: begin
            if (phase_ff == PH_WAIT) begin
               timeout_count_in    = '0;
               phase_in            = PH_DONE;
               res_valid           = 1'b1;
               res.action          = tbs_pkg::ACT_PEER_ERR;
               res.peer_error_code = item.rx_error_code;
            end
         end
         tbs_pkg::OP_OTHER: begin
            if (phase_ff == PH_WAIT) begin
               timeout_count_in = '0;
               phase_in         = PH_DONE;
               res_valid        = 1'b1;
               res.action       = tbs_pkg::ACT_PROTO_ERR;
            end
         end
         tbs_pkg::OP_TIMEOUT: begin
            if (phase_ff == PH_WAIT) begin
               timeout_count_in = timeout_inc;
               if (timeout_inc >= limit) begin
                  phase_in   = PH_DONE;
                  res_valid  = 1'b1;
                  res.action = tbs_pkg::ACT_TIMEOUT_ABORT;
               end else if (data_sent_once_ff) begin
                  res_valid     = 1'b1;
                  res.action    = tbs_pkg::ACT_RESEND;
                  res.tx_block  = expected_block_ff;
                  res.tx_length = sent_length_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         expected_block_ff <= '0;
         final_sent_ff     <= 1'b0;
         data_sent_once_ff <= 1'b0;
         timeout_count_ff  <= '0;
         sent_length_ff    <= '0;
      end else if (advance) begin
         phase_ff          <= phase_in;
         expected_block_ff <= expected_block_in;
         final_sent_ff     <= final_sent_in;
         data_sent_once_ff <= data_sent_once_in;
         timeout_count_ff  <= timeout_count_in;
         sent_length_ff    <= sent_length_in;
      end
   end

endmodule

### rtl/tbs_out_reg.sv
// Result register of the TFTP block sender: holds one word until taken.
// Depends on tbs_pkg for the result word type.
module tbs_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                load_valid,
   input  tbs_pkg::result_type load_data,
   input  logic                rsp_stall,
   output logic                full,
   output logic                rsp_valid,
   output tbs_pkg::result_type rsp_data
);

   logic                valid_ff, valid_in;
   tbs_pkg::result_type data_ff;

   assign valid_in  = load ? load_valid : (valid_ff && rsp_stall);
   assign full      = valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

### rtl/tftp_block_sender.sv
// TFTP lock-step block sender: input word register, decision core, result register.
// An event waits in the input word register; its result then waits in the result register.
// Throughput: one event per cycle unless a stalled, full result register holds it off.
// Synchronous active-high reset clears the transfer state and both valid flags;
// retry_limit resets to 1 and server_mode to 0. Depends on tbs_pkg, tbs_core, tbs_out_reg.
module tftp_block_sender (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tbs_pkg::OP_W-1:0]            req_operation,
   input  logic [tbs_pkg::BLOCK_W-1:0]         req_rx_block,
   input  logic [tbs_pkg::CODE_W-1:0]          req_rx_error_code,
   input  logic [tbs_pkg::LEN_W-1:0]           req_chunk_length,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tbs_pkg::OP_W-1:0]            rsp_action,
   output logic [tbs_pkg::BLOCK_W-1:0]         rsp_tx_block,
   output logic [tbs_pkg::LEN_W-1:0]           rsp_tx_length,
   output logic [tbs_pkg::CODE_W-1:0]          rsp_peer_error_code,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tbs_pkg::CSR_DATA_W-1:0]      csr_data
);

   tbs_pkg::cfg_type    cfg_ff;
   logic                in_valid_ff;
   tbs_pkg::item_type   item_ff;
   logic                advance;
   logic                out_full;
   logic                res_valid;
   tbs_pkg::result_type res;
   tbs_pkg::result_type rsp_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_limit <= tbs_pkg::LIMIT_W'(1);
         cfg_ff.server_mode <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tbs_pkg::REG_RETRY_LIMIT: cfg_ff.retry_limit <= csr_data[tbs_pkg::LIMIT_W-1:0];
            tbs_pkg::REG_SERVER_MODE: cfg_ff.server_mode <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // advance the held event when the result register is free or being drained
   assign advance   = in_valid_ff && (!out_full || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.operation     <= req_operation;
         item_ff.rx_block      <= req_rx_block;
         item_ff.rx_error_code <= req_rx_error_code;
         item_ff.chunk_length  <= req_chunk_length;
      end
   end

   tbs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item_ff),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   tbs_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (res_valid),
      .load_data  (res),
      .rsp_stall  (rsp_stall),
      .full       (out_full),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   assign rsp_action          = rsp_data.action;
   assign rsp_tx_block        = rsp_data.tx_block;
   assign rsp_tx_length       = rsp_data.tx_length;
   assign rsp_peer_error_code = rsp_data.peer_error_code;

endmodule

### rtl/tbs_checker.sv
// Port-level checks for the TFTP block sender, bound to the top level.
// Depends on tbs_pkg for action codes and field widths.
module tbs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [tbs_pkg::OP_W-1:0]        rsp_action,
   input logic [tbs_pkg::BLOCK_W-1:0]     rsp_tx_block,
   input logic [tbs_pkg::LEN_W-1:0]       rsp_tx_length,
   input logic [tbs_pkg::CODE_W-1:0]      rsp_peer_error_code
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_action))
      else $error("stalled result word dropped or changed");

   a_action_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_action <= tbs_pkg::ACT_TIMEOUT_ABORT)
      else $error("undefined action code");

   a_no_data_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != tbs_pkg::ACT_SEND && rsp_action != tbs_pkg::ACT_RESEND
      |-> rsp_tx_block == '0 && rsp_tx_length == '0)
      else $error("block or length on a non-data action");

   a_send_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == tbs_pkg::ACT_SEND
      |-> rsp_tx_length <= tbs_pkg::BLOCK_BYTES)
      else $error("data length above block size");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != tbs_pkg::ACT_PEER_ERR |-> rsp_peer_error_code == '0)
      else $error("error code on a non-error action");

endmodule

bind tftp_block_sender tbs_checker u_tbs_checker (.*);

### tb/sv/testbench.sv
// Self-checking bench for tftp_block_sender: directed transfers, retry and abort
// corners, a long multi-block transfer, receiver hold-off and random sessions.
// Depends on tbs_pkg and the tftp_block_sender RTL.
module testbench;
   import tbs_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_DONE} xfer_phase_type;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam int DRAIN_CYCLES = 6;
   localparam int PRINT_CAP    = 50;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [OP_W-1:0]        req_operation;
   logic [BLOCK_W-1:0]     req_rx_block;
   logic [CODE_W-1:0]      req_rx_error_code;
   logic [LEN_W-1:0]       req_chunk_length;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [OP_W-1:0]        rsp_action;
   logic [BLOCK_W-1:0]     rsp_tx_block;
   logic [LEN_W-1:0]       rsp_tx_length;
   logic [CODE_W-1:0]      rsp_peer_error_code;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   tftp_block_sender dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_rx_block        (req_rx_block),
      .req_rx_error_code   (req_rx_error_code),
      .req_chunk_length    (req_chunk_length),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_tx_block        (rsp_tx_block),
      .rsp_tx_length       (rsp_tx_length),
      .rsp_peer_error_code (rsp_peer_error_code),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   cfg_type            cfg = '{retry_limit: 8'd1, server_mode: 1'b0};
   xfer_phase_type     xfer_phase = PH_IDLE;
   logic [BLOCK_W-1:0] cur_block = '0;
   logic               final_pending = 1'b0;
   logic               data_sent = 1'b0;
   logic [LIMIT_W-1:0] timeouts_in_row = '0;
   logic [LEN_W-1:0]   sent_length = '0;

   result_type expected_actions[$];
   int  mismatches = 0;
   int  events_sent = 0;
   int  words_checked = 0;
   int  settings_used = 0;
   int  hold_cycles = 0;
   bit  steady = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("tftp_block_sender regression: fail");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP)
         $display("MISMATCH @%0t word %0d: %s", $time, words_checked, msg);
      mismatches++;
   endtask

   function automatic result_type next_block(input logic [LEN_W-1:0] chunk);
      result_type sent;
      sent = '0;
      sent_length = (chunk > BLOCK_BYTES) ? BLOCK_BYTES : chunk;
      cur_block = cur_block + 1'b1;
      final_pending = (sent_length < BLOCK_BYTES);
      data_sent = 1'b1;
      timeouts_in_row = '0;
      xfer_phase = PH_WAIT;
      sent.action = ACT_SEND;
      sent.tx_block = cur_block;
      sent.tx_length = sent_length;
      return sent;
   endfunction

   function automatic bit predict_action(input item_type word, output result_type want);
      logic [LIMIT_W-1:0] limit;
      want = '0;
      limit = (cfg.retry_limit == '0) ? LIMIT_W'(1) : cfg.retry_limit;
      if (word.operation == OP_START) begin
         if (xfer_phase == PH_WAIT)
            return 1'b0;
         cur_block = '0;
         final_pending = 1'b0;
         data_sent = 1'b0;
         timeouts_in_row = '0;
         sent_length = '0;
         xfer_phase = PH_WAIT;
         if (!cfg.server_mode)
            return 1'b0;
         want = next_block(word.chunk_length);
         return 1'b1;
      end
      if (xfer_phase != PH_WAIT || word.operation > OP_TIMEOUT)
         return 1'b0;
      if (word.operation == OP_TIMEOUT) begin
         timeouts_in_row = timeouts_in_row + 1'b1;
         if (timeouts_in_row >= limit) begin
            xfer_phase = PH_DONE;
            want.action = ACT_TIMEOUT_ABORT;
            return 1'b1;
         end
         if (!data_sent)
            return 1'b0;
         want.action = ACT_RESEND;
         want.tx_block = cur_block;
         want.tx_length = sent_length;
         return 1'b1;
      end
      timeouts_in_row = '0;
      if (word.operation == OP_ACK) begin
         if (word.rx_block != cur_block)
            return 1'b0;
         if (final_pending) begin
            xfer_phase = PH_DONE;
            want.action = ACT_FINISH;
            return 1'b1;
         end
         want = next_block(word.chunk_length);
         return 1'b1;
      end
      xfer_phase = PH_DONE;
      if (word.operation == OP_ERROR) begin
         want.action = ACT_PEER_ERR;
         want.peer_error_code = word.rx_error_code;
      end else begin
         want.action = ACT_PROTO_ERR;
      end
      return 1'b1;
   endfunction

   task automatic send_event(input logic [OP_W-1:0] op, input logic [BLOCK_W-1:0] blk,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
      item_type   word;
      result_type want;
      word.operation = op;
      word.rx_block = blk;
      word.rx_error_code = code;
      word.chunk_length = len;
      @(negedge clock);
      while (!steady && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_rx_block      <= blk;
      req_rx_error_code <= code;
      req_chunk_length  <= len;
      do @(posedge clock); while (req_stall);
      events_sent++;
      if (predict_action(word, want))
         expected_actions.push_back(want);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_actions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == REG_RETRY_LIMIT)
         cfg.retry_limit = data;
      else
         cfg.server_mode = data[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [LIMIT_W-1:0] limit, input logic mode);
      logic [CSR_DATA_W-1:0] mode_word;
      mode_word = {7'($urandom_range(127)), mode};
      settle();
      write_reg(REG_RETRY_LIMIT, limit);
      write_reg(REG_SERVER_MODE, mode_word);
      settings_used++;
   endtask

   function automatic logic [LEN_W-1:0] pick_chunk();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70)
         return BLOCK_BYTES;
      if (roll < 85)
         return LEN_W'($urandom_range(511));
      return LEN_W'($urandom_range(1023, 513));
   endfunction

   // receiver: random stalls, forced hold-off when requested
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 8);
         end
      end
   end

   initial begin
      result_type got;
      result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.action = rsp_action;
            got.tx_block = rsp_tx_block;
            got.tx_length = rsp_tx_length;
            got.peer_error_code = rsp_peer_error_code;
            words_checked++;
            if (expected_actions.size() == 0) begin
               report_mismatch($sformatf("unexpected word, action %0d", got.action));
            end else begin
               want = expected_actions.pop_front();
               if (got.action !== want.action)
                  report_mismatch($sformatf("action %0d, want %0d", got.action, want.action));
               if (got.tx_block !== want.tx_block)
                  report_mismatch($sformatf("tx_block 0x%0h, want 0x%0h",
                                            got.tx_block, want.tx_block));
               if (got.tx_length !== want.tx_length)
                  report_mismatch($sformatf("tx_length %0d, want %0d",
                                            got.tx_length, want.tx_length));
               if (got.peer_error_code !== want.peer_error_code)
                  report_mismatch($sformatf("peer_error_code 0x%0h, want 0x%0h",
                                            got.peer_error_code, want.peer_error_code));
            end
         end
      end
   end

   task automatic test_client_transfer();
      configure(8'd3, 1'b0);
      send_event(OP_TIMEOUT, 16'd0, 16'h1234, 10'd512);
      send_event(OP_START, 16'hFFFF, 16'h0000, 10'd1023);
      send_event(OP_TIMEOUT, 16'd0, 16'd0, 10'd0);
      send_event(OP_ACK, 16'd0, 16'hFFFF, 10'd512);
      send_event(OP_TIMEOUT, 16'd0, 16'd0, 10'd0);
      send_event(OP_ACK, 16'hFFFF, 16'd0, 10'd512);
      send_event(OP_TIMEOUT, 16'd0, 16'd0, 10'd0);
      send_event(OP_TIMEOUT, 16'd0, 16'd0, 10'd0);
      send_event(OP_ACK, 16'd1, 16'd0, 10'd1023);
      send_event(OP_START, 16'd0, 16'd0, 10'd5);
      send_event(OP_SPARE_LO, 16'd2, 16'd0, 10'd0);
      send_event(OP_SPARE_LO + 3'd1, 16'd2, 16'd0, 10'd0);
      send_event(OP_SPARE_HI, 16'd2, 16'hFFFF, 10'd0);
      send_event(OP_ACK, 16'd2, 16'd0, 10'd0);
      send_event(OP_ACK, 16'd3, 16'd0, 10'd0);
      send_event(OP_ACK, 16'd3, 16'd0, 10'd0);
   endtask

   task automatic test_server_aborts();
      configure(8'd0, 1'b1);
      send_event(OP_START, 16'd0, 16'd0, 10'd100);
      send_event(OP_ERROR, 16'd0, 16'hFFFF, 10'd0);
      send_event(OP_START, 16'd0, 16'd0, 10'd512);
      send_event(OP_OTHER, 16'd1, 16'h5A5A, 10'd0);
      send_event(OP_START, 16'd0, 16'd0, 10'd511);
      send_event(OP_TIMEOUT, 16'd0, 16'd0, 10'd0);
      send_event(OP_START, 16'd0, 16'd0, 10'd0);
      send_event(OP_ERROR, 16'd0, 16'h0000, 10'd0);
   endtask

   // long receiver hold-off while resends keep coming
   task automatic test_backpressure();
      configure(8'd255, 1'b1);
      steady = 1'b1;
      hold_cycles = 300;
      send_event(OP_START, 16'd0, 16'd0, 10'd512);
      repeat (255) send_event(OP_TIMEOUT, 16'($urandom), 16'($urandom), 10'd0);
      steady = 1'b0;
   endtask

   task automatic test_long_transfer();
      configure(8'd4, 1'b0);
      send_event(OP_START, 16'd0, 16'd0, 10'd0);
      send_event(OP_ACK, 16'd0, 16'd0, 10'd512);
      for (int n = 0; n < 100; n++) begin
         if ($urandom_range(19) == 0)
            send_event(OP_TIMEOUT, 16'($urandom), 16'($urandom), 10'($urandom));
         send_event(OP_ACK, cur_block, 16'($urandom), LEN_W'($urandom_range(1023, 512)));
      end
      send_event(OP_ACK, cur_block, 16'd0, 10'd17);
      send_event(OP_ACK, cur_block, 16'd0, 10'd0);
   endtask

   task automatic send_random_event();
      int                 roll;
      logic [BLOCK_W-1:0] blk;
      logic [CODE_W-1:0]  code;
      logic [LEN_W-1:0]   len;
      roll = $urandom_range(99);
      blk  = BLOCK_W'($urandom);
      code = CODE_W'($urandom);
      len  = pick_chunk();
      if (xfer_phase != PH_WAIT) begin
         if (roll < 80)
            send_event(OP_START, blk, code, len);
         else
            send_event(OP_W'($urandom_range(7)), blk, code, len);
      end else if (roll < 65) begin
         send_event(OP_ACK, cur_block, code, len);
      end else if (roll < 77) begin
         send_event(OP_TIMEOUT, blk, code, len);
      end else if (roll < 81) begin
         send_event(OP_ACK, cur_block - 1'b1, code, len);
      end else if (roll < 85) begin
         send_event(OP_ACK, blk, code, len);
      end else if (roll < 89) begin
         send_event(OP_ERROR, blk, code, len);
      end else if (roll < 92) begin
         send_event(OP_OTHER, blk, code, len);
      end else if (roll < 95) begin
         send_event(OP_START, blk, code, len);
      end else begin
         send_event(OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), blk, code, len);
      end
   endtask

   task automatic test_random_sessions();
      logic [LIMIT_W-1:0] limit;
      for (int round = 0; round < 4; round++) begin
         case (round)
            0: limit = 8'd0;
            1: limit = 8'd255;
            2: limit = 8'd2;
            default: limit = LIMIT_W'($urandom_range(255));
         endcase
         configure(limit, round[0]);
         steady = (round == 2);
         repeat (150) send_random_event();
      end
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_START;
      req_rx_block = '0;
      req_rx_error_code = '0;
      req_chunk_length = '0;
      csr_valid = 1'b0;
      csr_index = REG_RETRY_LIMIT;
      csr_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_client_transfer();
      test_server_aborts();
      test_backpressure();
      test_long_transfer();
      test_random_sessions();
      settle();

      if (expected_actions.size() != 0)
         report_mismatch($sformatf("%0d words never arrived", expected_actions.size()));
      $display("Ran %0d events, checked %0d result words across %0d register settings,",
               events_sent, words_checked, settings_used);
      $display("with a long multi-block transfer, retry aborts and a long receiver hold-off.");
      if (mismatches == 0) begin
         $display("tftp_block_sender regression: pass");
      end else begin
         $display("tftp_block_sender regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/tbs_pkg.sv
rtl/tbs_core.sv
rtl/tbs_out_reg.sv
rtl/tftp_block_sender.sv
rtl/tbs_checker.sv
tb/sv/testbench.sv
